[rtl/core/i2cmra_pkg.sv]
package i2cmra_pkg;

  localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd16;
  localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd250;

  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_TICKS_PER_UNIT = 1'b0;
  localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

  localparam logic [7:0] READ_BIT = 8'h01;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy;
    logic       done;
    logic       nack;
  } res_t;

endpackage

[rtl/core/i2cmra_in_stage.sv]
module i2cmra_in_stage
  import i2cmra_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  fire,
  output logic  held_valid,
  output item_t held_item
);

  logic  valid;
  item_t item;

  assign in_stall   = valid && !fire;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      valid <= 1'b1;
    end else if (fire) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

[rtl/core/i2cmra_seq.sv]
module i2cmra_seq
  import i2cmra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  logic [15:0] ticks_per_unit,
  input  logic [7:0]  ack_poll_limit,
  output res_t        res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_WB_BIT, PH_WB_HIGH, PH_WA1, PH_WA2,
    PH_POLL, PH_WA_END, PH_NEXT, PH_RD_PRE, PH_RD_HIGH, PH_RD_SAMPLE,
    PH_AK1, PH_AK2, PH_AK3, PH_NA1, PH_NA2, PH_NA3, PH_SP1, PH_SP2, PH_SP3,
    PH_END
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] delay_count, delay_count_next;
  logic [1:0]  units_left, units_left_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [7:0]  saved_device, saved_device_next;
  logic [7:0]  saved_register, saved_register_next;
  logic [7:0]  saved_data, saved_data_next;
  logic [1:0]  saved_operation, saved_operation_next;
  logic [1:0]  stage, stage_next;
  logic        nack_flag, nack_flag_next;
  logic        scl_drive, scl_drive_next;
  logic        sda_drive, sda_drive_next;

  logic [15:0] unit_m1;
  logic        go;
  logic        timed;
  logic [7:0]  rbyte;
  logic        rvalid;
  logic        rlast;
  logic        busy;
  logic        done;

  // zero ticks per unit behaves as one
  assign unit_m1 = (ticks_per_unit == 16'd0) ? 16'd0 : ticks_per_unit - 16'd1;

  always_comb begin
    phase_next           = phase;
    bit_index_next       = bit_index;
    shift_byte_next      = shift_byte;
    bytes_left_next      = bytes_left;
    delay_count_next     = delay_count;
    units_left_next      = units_left;
    poll_count_next      = poll_count;
    saved_device_next    = saved_device;
    saved_register_next  = saved_register;
    saved_data_next      = saved_data;
    saved_operation_next = saved_operation;
    stage_next           = stage;
    nack_flag_next       = nack_flag;
    scl_drive_next       = scl_drive;
    sda_drive_next       = sda_drive;
    go     = 1'b0;
    timed  = 1'b0;
    rbyte  = 8'd0;
    rvalid = 1'b0;
    rlast  = 1'b0;
    busy   = 1'b0;
    done   = 1'b0;

    if (phase == PH_IDLE && (item.operation == OP_WRITE || item.operation == OP_READ)) begin
      saved_operation_next = item.operation;
      saved_device_next    = item.device_address;
      saved_register_next  = item.register_address;
      saved_data_next      = item.write_data;
      bytes_left_next      = item.read_length;
      shift_byte_next      = item.device_address;
      nack_flag_next       = 1'b0;
      stage_next           = 2'd0;
      delay_count_next     = 16'd0;
      units_left_next      = 2'd0;
      phase_next           = PH_ST1;
    end

    if (phase_next != PH_IDLE) begin
      busy = 1'b1;
      if (delay_count_next != 16'd0 || units_left_next != 2'd0) begin
        if (delay_count_next != 16'd0) begin
          delay_count_next = delay_count_next - 16'd1;
        end else begin
          units_left_next  = units_left_next - 2'd1;
          delay_count_next = unit_m1;
        end
      end else begin
        go = 1'b1;
        // untimed steps fall through into the next timed step on the same tick
        case (phase_next)
          PH_POLL: begin
            if (!item.sda_sample) begin
              phase_next = PH_WA_END;
            end else if (poll_count_next >= ack_poll_limit) begin
              nack_flag_next = 1'b1;
              phase_next     = PH_WA_END;
            end else begin
              poll_count_next = poll_count_next + 8'd1;
              go              = 1'b0;
            end
          end
          PH_NEXT: begin
            if (stage_next == 2'd0) begin
              shift_byte_next = saved_register_next;
              stage_next      = 2'd1;
              bit_index_next  = 4'd0;
              phase_next      = PH_WB_BIT;
            end else if (stage_next == 2'd1) begin
              stage_next = 2'd2;
              if (saved_operation_next == OP_WRITE) begin
                shift_byte_next = saved_data_next;
                bit_index_next  = 4'd0;
                phase_next      = PH_WB_BIT;
              end else begin
                shift_byte_next = saved_device_next | READ_BIT;
                phase_next      = PH_ST1;
              end
            end else if (saved_operation_next == OP_READ) begin
              phase_next = (bytes_left_next != 8'd0) ? PH_RD_PRE : PH_NA1;
            end else begin
              phase_next = PH_SP1;
            end
          end
          PH_IDLE, PH_END: go = 1'b0;
          default: ;
        endcase

        if (go) begin
          timed = 1'b1;
          case (phase_next)
            PH_ST1: begin
              sda_drive_next = 1'b1; scl_drive_next = 1'b1;
              phase_next = PH_ST2; units_left_next = 2'd0;
            end
            PH_ST2: begin
              sda_drive_next = 1'b0;
              phase_next = PH_ST3; units_left_next = 2'd0;
            end
            PH_ST3: begin
              scl_drive_next = 1'b0; bit_index_next = 4'd0;
              phase_next = PH_WB_BIT; units_left_next = 2'd1;
            end
            PH_WB_BIT: begin
              scl_drive_next = 1'b0;
              sda_drive_next = shift_byte_next[7];
              phase_next = PH_WB_HIGH; units_left_next = 2'd1;
            end
            PH_WB_HIGH: begin
              scl_drive_next  = 1'b1;
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
              bit_index_next  = bit_index_next + 4'd1;
              phase_next = (bit_index_next >= 4'd8) ? PH_WA1 : PH_WB_BIT;
              units_left_next = 2'd1;
            end
            PH_WA1: begin
              scl_drive_next = 1'b0; sda_drive_next = 1'b1;
              phase_next = PH_WA2; units_left_next = 2'd1;
            end
            PH_WA2: begin
              scl_drive_next = 1'b1; poll_count_next = 8'd0;
              phase_next = PH_POLL; units_left_next = 2'd0;
            end
            PH_WA_END: begin
              scl_drive_next = 1'b0;
              phase_next = PH_NEXT; units_left_next = 2'd2;
            end
            PH_RD_PRE: begin
              sda_drive_next = 1'b1; bit_index_next = 4'd0;
              phase_next = PH_RD_HIGH; units_left_next = 2'd1;
            end
            PH_RD_HIGH: begin
              sda_drive_next = 1'b1; scl_drive_next = 1'b1;
              phase_next = PH_RD_SAMPLE; units_left_next = 2'd1;
            end
            PH_RD_SAMPLE: begin
              shift_byte_next = {shift_byte_next[6:0], item.sda_sample};
              scl_drive_next  = 1'b0;
              bit_index_next  = bit_index_next + 4'd1;
              units_left_next = 2'd1;
              if (bit_index_next >= 4'd8) begin
                rbyte           = shift_byte_next;
                rvalid          = 1'b1;
                bytes_left_next = bytes_left_next - 8'd1;
                rlast           = (bytes_left_next == 8'd0);
                phase_next      = (bytes_left_next != 8'd0) ? PH_AK1 : PH_NA1;
              end else begin
                phase_next = PH_RD_HIGH;
              end
            end
            PH_AK1: begin
              sda_drive_next = 1'b0;
              phase_next = PH_AK2; units_left_next = 2'd0;
            end
            PH_AK2: begin
              scl_drive_next = 1'b1;
              phase_next = PH_AK3; units_left_next = 2'd0;
            end
            PH_AK3: begin
              scl_drive_next = 1'b0;
              phase_next = PH_RD_PRE; units_left_next = 2'd1;
            end
            PH_NA1: begin
              sda_drive_next = 1'b1;
              phase_next = PH_NA2; units_left_next = 2'd0;
            end
            PH_NA2: begin
              scl_drive_next = 1'b1;
              phase_next = PH_NA3; units_left_next = 2'd0;
            end
            PH_NA3: begin
              scl_drive_next = 1'b0;
              phase_next = PH_SP1; units_left_next = 2'd1;
            end
            PH_SP1: begin
              scl_drive_next = 1'b0; sda_drive_next = 1'b0;
              phase_next = PH_SP2; units_left_next = 2'd0;
            end
            PH_SP2: begin
              scl_drive_next = 1'b1;
              phase_next = PH_SP3; units_left_next = 2'd0;
            end
            PH_SP3: begin
              sda_drive_next = 1'b1;
              phase_next = PH_END; units_left_next = 2'd1;
            end
            default: timed = 1'b0;
          endcase
          if (timed) begin
            delay_count_next = unit_m1;
          end
        end
      end

      if (delay_count_next == 16'd0 && units_left_next == 2'd0 && phase_next == PH_END) begin
        phase_next = PH_IDLE;
        done       = 1'b1;
      end
    end
  end

  always_comb begin
    res.scl_level  = scl_drive_next;
    res.sda_level  = sda_drive_next;
    res.read_byte  = rbyte;
    res.read_valid = rvalid;
    res.read_last  = rlast;
    res.busy       = busy;
    res.done       = done;
    res.nack       = nack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_index       <= 4'd0;
      shift_byte      <= 8'd0;
      bytes_left      <= 8'd0;
      delay_count     <= 16'd0;
      units_left      <= 2'd0;
      poll_count      <= 8'd0;
      saved_device    <= 8'd0;
      saved_register  <= 8'd0;
      saved_data      <= 8'd0;
      saved_operation <= 2'd0;
      stage           <= 2'd0;
      nack_flag       <= 1'b0;
      scl_drive       <= 1'b1;
      sda_drive       <= 1'b1;
    end else if (fire) begin
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      bytes_left      <= bytes_left_next;
      delay_count     <= delay_count_next;
      units_left      <= units_left_next;
      poll_count      <= poll_count_next;
      saved_device    <= saved_device_next;
      saved_register  <= saved_register_next;
      saved_data      <= saved_data_next;
      saved_operation <= saved_operation_next;
      stage           <= stage_next;
      nack_flag       <= nack_flag_next;
      scl_drive       <= scl_drive_next;
      sda_drive       <= sda_drive_next;
    end
  end

endmodule

[rtl/core/i2cmra_out_stage.sv]
module i2cmra_out_stage
  import i2cmra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  res_t res,
  output logic ready,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic valid;
  res_t data;

  assign ready     = !valid || !out_stall;
  assign out_valid = valid;
  assign out_res   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire) begin
      valid <= 1'b1;
    end else if (!out_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data <= res;
    end
  end

endmodule

[rtl/core/i2c_master_register_access_unit.sv]
// I2C master for register write and burst register read, stepped one bus
// tick per input beat. Each input beat carries the sampled SDA level and,
// while the master is idle, an operation (1 write, 2 burst read, else none).
// Each input beat yields exactly one output beat with the SCL/SDA drive
// levels after that tick, a read byte strobe with its last flag, busy, done
// and a sticky no-ack flag that clears when a new command starts.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. An input register feeds a single pass of next-state logic whose
// result lands in an output register, and one beat per cycle is sustained
// while the output is not stalled. A stalled output holds its beat while
// one more input beat is taken into the input register; further input is
// stalled until the output drains. Configuration (ticks per delay unit,
// ack poll limit) is written through cfg_wr_en/cfg_index/cfg_data; the
// user must do so only while the master is idle, as the block does not
// enforce it. Reset is synchronous: the sequencer returns to idle with
// both lines released, pipeline stages empty, config back to 16 ticks and
// 250 polls.
module i2c_master_register_access_unit
  import i2cmra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  device_address,
  input  logic [7:0]  register_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  read_length,
  input  logic        sda_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic        read_last,
  output logic        busy_res,
  output logic        done_res,
  output logic        nack_seen
);

  logic [15:0] ticks_per_unit;
  logic [7:0]  ack_poll_limit;
  item_t       in_item;
  item_t       held_item;
  logic        held_valid;
  logic        ready;
  logic        fire;
  res_t        res;
  res_t        out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TICKS_PER_UNIT_RESET;
      ack_poll_limit <= ACK_POLL_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TICKS_PER_UNIT: ticks_per_unit <= cfg_data;
        CFG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_item.operation        = operation;
  assign in_item.device_address   = device_address;
  assign in_item.register_address = register_address;
  assign in_item.write_data       = write_data;
  assign in_item.read_length      = read_length;
  assign in_item.sda_sample       = sda_sample;

  assign fire = held_valid && ready;

  i2cmra_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .fire       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  i2cmra_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (held_item),
    .ticks_per_unit (ticks_per_unit),
    .ack_poll_limit (ack_poll_limit),
    .res            (res)
  );

  i2cmra_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign scl_level  = out_res.scl_level;
  assign sda_level  = out_res.sda_level;
  assign read_byte  = out_res.read_byte;
  assign read_valid = out_res.read_valid;
  assign read_last  = out_res.read_last;
  assign busy_res   = out_res.busy;
  assign done_res   = out_res.done;
  assign nack_seen  = out_res.nack;

endmodule
